### hdl/midi_event_byte_encoder_defines.svh
// Assertion helpers shared by the encoder modules.
`ifndef MIDI_EVENT_BYTE_ENCODER_DEFINES_SVH
`define MIDI_EVENT_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MEBE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MEBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mebe_pkg.sv
package mebe_pkg;

    // Event modes
    localparam logic [3:0] MODE_NOTE_ON  = 4'd0;
    localparam logic [3:0] MODE_PROGRAM  = 4'd1;
    localparam logic [3:0] MODE_BEND     = 4'd2;
    localparam logic [3:0] MODE_CTRL     = 4'd3;
    localparam logic [3:0] MODE_TEMPO    = 4'd4;
    localparam logic [3:0] MODE_TIMESIG  = 4'd5;
    localparam logic [3:0] MODE_END      = 4'd6;
    localparam logic [3:0] MODE_BANK     = 4'd7;
    localparam logic [3:0] MODE_RPN      = 4'd8;
    localparam logic [3:0] MODE_RPN_LSB  = 4'd9;
    localparam logic [3:0] MODE_NRPN     = 4'd10;
    localparam logic [3:0] MODE_NRPN_LSB = 4'd11;

    // Status bytes
    localparam logic [7:0] ST_NOTE_ON = 8'h90;
    localparam logic [7:0] ST_CTRL    = 8'hB0;
    localparam logic [7:0] ST_PROGRAM = 8'hC0;
    localparam logic [7:0] ST_BEND    = 8'hE0;
    localparam logic [7:0] ST_META    = 8'hFF;

    // Meta event types
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_END     = 8'h2F;

    // Controller numbers
    localparam logic [7:0] CC_BANK_MSB  = 8'd0;
    localparam logic [7:0] CC_BANK_LSB  = 8'd32;
    localparam logic [7:0] CC_RPN_MSB   = 8'd101;
    localparam logic [7:0] CC_RPN_LSB   = 8'd100;
    localparam logic [7:0] CC_NRPN_MSB  = 8'd99;
    localparam logic [7:0] CC_NRPN_LSB  = 8'd98;
    localparam logic [7:0] CC_DATA_MSB  = 8'd6;
    localparam logic [7:0] CC_DATA_LSB  = 8'd38;

    // Variable-length quantity thresholds
    localparam logic [27:0] VLQ_LIM4 = 28'h01FFFFF;
    localparam logic [27:0] VLQ_LIM3 = 28'h0003FFF;
    localparam logic [27:0] VLQ_LIM2 = 28'h000007F;

    // Longest body: four control changes, delta zero between them
    localparam int MAX_BODY = 15;

    typedef logic [MAX_BODY-1:0][7:0] t_body;

    // One classified event, waiting for the byte sequencer
    typedef struct packed {
        logic [27:0] delta;
        logic [1:0]  ndelta_m1;
        logic [3:0]  body_len;
        t_body       body;
    } t_desc;

endpackage

### hdl/mebe_front.sv
module mebe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [3:0]        i_mode,
    input  logic [27:0]       i_delta_time,
    input  logic [3:0]        i_channel,
    input  logic [7:0]        i_first_byte,
    input  logic [7:0]        i_second_byte,
    input  logic [7:0]        i_third_byte,
    input  logic [7:0]        i_fourth_byte,
    input  logic [23:0]       i_wide_value,
    input  logic              i_q_full,
    output logic              o_q_push,
    output mebe_pkg::t_desc   o_q_data
);

    logic [7:0]      r_last_status;
    logic [7:0]      n_last_status;
    logic            known;
    logic            running;
    logic            skip;
    logic            accept;
    logic [7:0]      st_ch;
    logic [7:0]      ctl_st;
    logic [7:0]      num_hi;
    logic [7:0]      num_lo;
    logic [7:0]      b1_7;
    logic [7:0]      b2_7;
    logic [7:0]      hi_ctl;
    logic [7:0]      lo_ctl;
    mebe_pkg::t_body full_body;
    logic [3:0]      full_len;
    mebe_pkg::t_body body;
    logic [3:0]      body_len;
    logic [1:0]      ndelta_m1;

    // Classify the mode
    assign known   = i_mode inside {[mebe_pkg::MODE_NOTE_ON:mebe_pkg::MODE_NRPN_LSB]};
    assign running = i_mode inside {mebe_pkg::MODE_NOTE_ON, mebe_pkg::MODE_PROGRAM,
                                    mebe_pkg::MODE_BEND};
    assign accept  = i_push && !i_q_full;

    assign ctl_st = mebe_pkg::ST_CTRL | {4'h0, i_channel};
    assign num_hi = {1'b0, i_wide_value[13:7]};
    assign num_lo = {1'b0, i_wide_value[6:0]};
    assign b1_7   = {1'b0, i_first_byte[6:0]};
    assign b2_7   = {1'b0, i_second_byte[6:0]};

    // Pick the channel status byte of running-status events
    always_comb begin
        case (i_mode)
            mebe_pkg::MODE_NOTE_ON: st_ch = mebe_pkg::ST_NOTE_ON | {4'h0, i_channel};
            mebe_pkg::MODE_PROGRAM: st_ch = mebe_pkg::ST_PROGRAM | {4'h0, i_channel};
            default:                st_ch = mebe_pkg::ST_BEND | {4'h0, i_channel};
        endcase
    end

    assign skip = running && (st_ch == r_last_status);

    // Parameter-number controllers
    always_comb begin
        if (i_mode inside {mebe_pkg::MODE_RPN, mebe_pkg::MODE_RPN_LSB}) begin
            hi_ctl = mebe_pkg::CC_RPN_MSB;
            lo_ctl = mebe_pkg::CC_RPN_LSB;
        end else begin
            hi_ctl = mebe_pkg::CC_NRPN_MSB;
            lo_ctl = mebe_pkg::CC_NRPN_LSB;
        end
    end

    // Build the event body with its status byte in front
    always_comb begin
        full_body = '0;
        full_len  = 4'd0;
        case (i_mode)
            mebe_pkg::MODE_NOTE_ON: begin
                full_body[0] = st_ch;
                full_body[1] = b1_7;
                full_body[2] = b2_7;
                full_len     = 4'd3;
            end
            mebe_pkg::MODE_PROGRAM: begin
                full_body[0] = st_ch;
                full_body[1] = b1_7;
                full_len     = 4'd2;
            end
            mebe_pkg::MODE_BEND: begin
                full_body[0] = st_ch;
                full_body[1] = num_lo;
                full_body[2] = num_hi;
                full_len     = 4'd3;
            end
            mebe_pkg::MODE_CTRL: begin
                full_body[0] = ctl_st;
                full_body[1] = b1_7;
                full_body[2] = b2_7;
                full_len     = 4'd3;
            end
            mebe_pkg::MODE_TEMPO: begin
                full_body[0] = mebe_pkg::ST_META;
                full_body[1] = mebe_pkg::META_TEMPO;
                full_body[2] = 8'd3;
                full_body[3] = i_wide_value[23:16];
                full_body[4] = i_wide_value[15:8];
                full_body[5] = i_wide_value[7:0];
                full_len     = 4'd6;
            end
            mebe_pkg::MODE_TIMESIG: begin
                full_body[0] = mebe_pkg::ST_META;
                full_body[1] = mebe_pkg::META_TIMESIG;
                full_body[3] = i_first_byte;
                full_body[4] = i_second_byte;
                if ((i_third_byte != 8'd0) || (i_fourth_byte != 8'd0)) begin
                    full_body[2] = 8'd4;
                    full_body[5] = i_third_byte;
                    full_body[6] = i_fourth_byte;
                    full_len     = 4'd7;
                end else begin
                    full_body[2] = 8'd2;
                    full_len     = 4'd5;
                end
            end
            mebe_pkg::MODE_END: begin
                full_body[0] = mebe_pkg::ST_META;
                full_body[1] = mebe_pkg::META_END;
                full_body[2] = 8'd0;
                full_len     = 4'd3;
            end
            mebe_pkg::MODE_BANK: begin
                full_body[0] = ctl_st;
                full_body[1] = mebe_pkg::CC_BANK_MSB;
                full_body[2] = num_hi;
                full_body[3] = 8'd0;
                full_body[4] = ctl_st;
                full_body[5] = mebe_pkg::CC_BANK_LSB;
                full_body[6] = num_lo;
                full_len     = 4'd7;
            end
            mebe_pkg::MODE_RPN, mebe_pkg::MODE_RPN_LSB,
            mebe_pkg::MODE_NRPN, mebe_pkg::MODE_NRPN_LSB: begin
                full_body[0]  = ctl_st;
                full_body[1]  = hi_ctl;
                full_body[2]  = num_hi;
                full_body[3]  = 8'd0;
                full_body[4]  = ctl_st;
                full_body[5]  = lo_ctl;
                full_body[6]  = num_lo;
                full_body[7]  = 8'd0;
                full_body[8]  = ctl_st;
                full_body[9]  = mebe_pkg::CC_DATA_MSB;
                full_body[10] = b1_7;
                full_len      = 4'd11;
                if (i_mode inside {mebe_pkg::MODE_RPN_LSB, mebe_pkg::MODE_NRPN_LSB}) begin
                    full_body[11] = 8'd0;
                    full_body[12] = ctl_st;
                    full_body[13] = mebe_pkg::CC_DATA_LSB;
                    full_body[14] = b2_7;
                    full_len      = 4'd15;
                end
            end
            default: begin
                full_body = '0;
                full_len  = 4'd0;
            end
        endcase
    end

    // Drop the status byte when running status allows it
    always_comb begin
        body     = full_body;
        body_len = full_len;
        if (skip) begin
            for (int i = 0; i < mebe_pkg::MAX_BODY - 1; i++) begin
                body[i] = full_body[i+1];
            end
            body[mebe_pkg::MAX_BODY-1] = 8'd0;
            body_len = full_len - 4'd1;
        end
    end

    // Count delta time groups
    always_comb begin
        if (i_delta_time > mebe_pkg::VLQ_LIM4) begin
            ndelta_m1 = 2'd3;
        end else if (i_delta_time > mebe_pkg::VLQ_LIM3) begin
            ndelta_m1 = 2'd2;
        end else if (i_delta_time > mebe_pkg::VLQ_LIM2) begin
            ndelta_m1 = 2'd1;
        end else begin
            ndelta_m1 = 2'd0;
        end
    end

    assign o_q_push            = accept && known;
    assign o_q_data.delta      = i_delta_time;
    assign o_q_data.ndelta_m1  = ndelta_m1;
    assign o_q_data.body_len   = body_len;
    assign o_q_data.body       = body;

    // Track the last status byte sent
    always_comb begin
        n_last_status = r_last_status;
        if (accept && known) begin
            if (running) begin
                n_last_status = st_ch;
            end else if (i_mode inside {mebe_pkg::MODE_TEMPO, mebe_pkg::MODE_TIMESIG,
                                        mebe_pkg::MODE_END}) begin
                n_last_status = mebe_pkg::ST_META;
            end else begin
                n_last_status = ctl_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_status <= 8'd0;
        end else begin
            r_last_status <= n_last_status;
        end
    end

endmodule

### hdl/mebe_queue.sv
`include "midi_event_byte_encoder_defines.svh"

module mebe_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mebe_pkg::t_desc i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mebe_pkg::t_desc o_data,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mebe_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MEBE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "queue over depth")
    `MEBE_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, wr_en && !rd_en, r_count == $past(r_count) + 1'b1, "queue count did not grow")
    `MEBE_ASSERT_NOW(a_ptr_match, i_clk, i_rst_n, o_empty || o_full, r_wr_ptr == r_rd_ptr, "queue pointers disagree with count")

endmodule

### hdl/mebe_back.sv
`include "midi_event_byte_encoder_defines.svh"

module mebe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mebe_pkg::t_desc i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_event
);

    logic            r_busy;
    mebe_pkg::t_desc r_cur;
    logic [4:0]      r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic [4:0]      total;
    logic [4:0]      ndelta;
    logic            cur_last;
    logic            adv;
    logic            load;
    logic [1:0]      grp;
    logic [6:0]      grp_bits;
    logic [4:0]      body_idx;
    logic [7:0]      cur_byte;

    assign ndelta   = {3'd0, r_cur.ndelta_m1} + 5'd1;
    assign total    = ndelta + {1'b0, r_cur.body_len};
    assign cur_last = (r_idx == total - 5'd1);
    assign adv      = r_busy && (!r_out_valid || i_pop);
    assign load     = (!r_busy || (adv && cur_last)) && !i_q_empty;
    assign o_q_pop  = load;

    // Select the delta time group, most significant first
    assign grp = r_cur.ndelta_m1 - r_idx[1:0];
    always_comb begin
        case (grp)
            2'd3:    grp_bits = r_cur.delta[27:21];
            2'd2:    grp_bits = r_cur.delta[20:14];
            2'd1:    grp_bits = r_cur.delta[13:7];
            default: grp_bits = r_cur.delta[6:0];
        endcase
    end

    // Pick the byte at the current position
    assign body_idx = r_idx - ndelta;
    always_comb begin
        if (r_idx < ndelta) begin
            cur_byte = {(grp != 2'd0), grp_bits};
        end else begin
            cur_byte = r_cur.body[body_idx[3:0]];
        end
    end

    // Load the next event or step through the current one
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 5'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 5'd0;
        end else if (adv && cur_last) begin
            r_busy <= 1'b0;
            r_idx  <= 5'd0;
        end else if (adv) begin
            r_idx  <= r_idx + 5'd1;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_event = r_out_last;

    `MEBE_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_busy, r_idx < total, "byte index past event end")
    `MEBE_ASSERT_NEXT(a_step, i_clk, i_rst_n, adv && !cur_last, r_busy && (r_idx == $past(r_idx) + 5'd1), "sequencer did not step")
    `MEBE_ASSERT_NEXT(a_last_flag, i_clk, i_rst_n, adv, r_out_valid && (r_out_last == $past(cur_last)), "last flag not carried")

endmodule

### hdl/midi_event_byte_encoder.sv
// MIDI event byte encoder.
// Input channel: a queue-style push port. One event (mode, delta time, channel,
// data bytes, wide value) is taken at a clock edge with push high and full low.
// Modes outside the defined set are taken and produce nothing.
// Output channel: a queue-style pop port. While empty is low the oldest track
// byte is on o_out_byte, with o_last_of_event marking the final byte of the
// event; it is taken at an edge with pop high.
// An accepted event passes through the queue, the sequencer's event register
// and the output register before its first byte appears. Throughput: the byte
// sequencer emits one byte per cycle while events wait and pop is high.
// An event is 2 to 19 bytes. Events are classified on entry and wait in a
// QUEUE_DEPTH-entry queue, so push stays open while earlier events are sent.
// Reset: synchronous, active low; clears the queue, the sequencer, the output
// register and running status (no status byte counts as sent).
// When the receiver stalls, the output byte holds, the sequencer pauses, the
// queue fills and full rises.
module midi_event_byte_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_mode,
    input  logic [27:0] i_delta_time,
    input  logic [3:0]  i_channel,
    input  logic [7:0]  i_first_byte,
    input  logic [7:0]  i_second_byte,
    input  logic [7:0]  i_third_byte,
    input  logic [7:0]  i_fourth_byte,
    input  logic [23:0] i_wide_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_event
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    mebe_pkg::t_desc q_wr_data;
    mebe_pkg::t_desc q_rd_data;

    assign full = q_full;

    // Classify events and track running status
    mebe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_mode        (i_mode),
        .i_delta_time  (i_delta_time),
        .i_channel     (i_channel),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .i_fourth_byte (i_fourth_byte),
        .i_wide_value  (i_wide_value),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wr_data)
    );

    // Decouple classification from byte emission
    mebe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // Emit track bytes
    mebe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (q_rd_data),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_last_of_event (o_last_of_event)
    );

endmodule
